// ===== rtl/bqd_pkg.sv =====
// bqd_pkg: shared types, constants and fp32 arithmetic for the bf16 query dot block.
// No dependencies.
package bqd_pkg;

  localparam int unsigned CFG_W     = 11;
  localparam logic [CFG_W-1:0] LEN_RESET = 11'd1024;
  localparam int unsigned Q_DEPTH   = 4;
  localparam int unsigned Q_PW      = $clog2(Q_DEPTH);
  localparam int unsigned Q_CW      = $clog2(Q_DEPTH + 1);

  localparam logic KIND_QUERY = 1'b0;
  localparam logic KIND_BASE  = 1'b1;

  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
  localparam logic [31:0] POS_INF   = 32'h7F80_0000;
  localparam logic [31:0] POS_ZERO  = 32'h0000_0000;

  // one base element on its way from front to back
  typedef struct packed {
    logic [15:0] base;
    logic [15:0] query;
    logic        first;
    logic        last;
    logic [15:0] vidx;
  } op_t;

  typedef struct packed {
    logic [31:0] prod;
    logic        first;
    logic        last;
    logic [15:0] vidx;
  } prod_t;

  function automatic logic fp32_is_nan(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
  endfunction

  function automatic logic [31:0] fp32_canon(input logic [31:0] x);
    return fp32_is_nan(x) ? CANON_NAN : x;
  endfunction

  // bf16 x bf16 widened to fp32; significand product is exact, rounding only
  // happens when the result drops into the subnormal range
  function automatic logic [31:0] bf16_mul(input logic [15:0] a, input logic [15:0] b);
    logic               sgn;
    logic [7:0]         ea, eb;
    logic [7:0]         ma, mb;
    logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [15:0]        p, pn;
    logic [4:0]         lz;
    logic signed [10:0] be;
    logic [4:0]         sh;
    logic [49:0]        tmp;
    logic [23:0]        mnt;
    logic               guard, sticky, rnd;
    logic [31:0]        res;
    sgn    = a[15] ^ b[15];
    a_nan  = (a[14:7] == 8'hFF) && (a[6:0] != 7'd0);
    b_nan  = (b[14:7] == 8'hFF) && (b[6:0] != 7'd0);
    a_inf  = (a[14:7] == 8'hFF) && (a[6:0] == 7'd0);
    b_inf  = (b[14:7] == 8'hFF) && (b[6:0] == 7'd0);
    a_zero = (a[14:0] == 15'd0);
    b_zero = (b[14:0] == 15'd0);
    ea     = (a[14:7] == 8'd0) ? 8'd1 : a[14:7];
    eb     = (b[14:7] == 8'd0) ? 8'd1 : b[14:7];
    ma     = {a[14:7] != 8'd0, a[6:0]};
    mb     = {b[14:7] != 8'd0, b[6:0]};
    p      = 16'(ma * mb);
    lz     = 5'd0;
    for (int i = 0; i < 16; i++) begin
      if (p[i]) lz = 5'(15 - i);
    end
    pn     = p << lz;
    be     = $signed({3'b000, ea}) + $signed({3'b000, eb}) - 11'sd126
             - $signed({6'b000000, lz});
    sh     = (be < -11'sd24) ? 5'd25 : 5'(11'sd1 - be);
    tmp    = {pn, 8'd0, 26'd0} >> sh;
    mnt    = tmp[49:26];
    guard  = tmp[25];
    sticky = |tmp[24:0];
    rnd    = guard && (sticky || mnt[0]);
    if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf)) begin
      res = CANON_NAN;
    end else if (a_inf || b_inf) begin
      res = {sgn, POS_INF[30:0]};
    end else if (a_zero || b_zero) begin
      res = {sgn, 31'd0};
    end else if (be >= 11'sd255) begin
      res = {sgn, POS_INF[30:0]};
    end else if (be >= 11'sd1) begin
      res = {sgn, be[7:0], pn[14:0], 8'd0};
    end else begin
      res = {sgn, 31'(mnt)} + 32'(rnd);
    end
    return res;
  endfunction

  // fp32 add, round to nearest even, subnormals kept
  function automatic logic [31:0] fp32_add(input logic [31:0] x, input logic [31:0] y);
    logic [31:0] a, b;
    logic        sa, sb;
    logic [7:0]  ea, eb;
    logic [23:0] ma, mb;
    logic        x_nan, y_nan, x_inf, y_inf;
    logic [8:0]  d;
    logic [4:0]  dc;
    logic [53:0] tmp;
    logic [26:0] ax, bx;
    logic [27:0] s;
    logic [8:0]  e;
    logic [4:0]  lz;
    logic [8:0]  shl;
    logic [26:0] n;
    logic [7:0]  ef;
    logic        rnd;
    logic [31:0] res;
    x_nan = fp32_is_nan(x);
    y_nan = fp32_is_nan(y);
    x_inf = (x[30:0] == POS_INF[30:0]);
    y_inf = (y[30:0] == POS_INF[30:0]);
    if (x[30:0] >= y[30:0]) begin
      a = x;
      b = y;
    end else begin
      a = y;
      b = x;
    end
    sa  = a[31];
    sb  = b[31];
    ea  = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb  = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma  = {a[30:23] != 8'd0, a[22:0]};
    mb  = {b[30:23] != 8'd0, b[22:0]};
    d   = {1'b0, ea} - {1'b0, eb};
    dc  = (d > 9'd27) ? 5'd27 : d[4:0];
    tmp = {mb, 3'b000, 27'd0} >> dc;
    bx  = {tmp[53:28], tmp[27] | (|tmp[26:0])};
    ax  = {ma, 3'b000};
    s   = (sa == sb) ? ({1'b0, ax} + {1'b0, bx}) : ({1'b0, ax} - {1'b0, bx});
    e   = {1'b0, ea};
    lz  = 5'd27;
    for (int i = 0; i < 27; i++) begin
      if (s[i]) lz = 5'(26 - i);
    end
    shl = 9'd0;
    if (s[27]) begin
      n = {s[27:2], s[1] | s[0]};
      e = e + 9'd1;
    end else begin
      shl = ({4'd0, lz} > (e - 9'd1)) ? (e - 9'd1) : {4'd0, lz};
      n   = s[26:0] << shl;
      e   = e - shl;
    end
    ef  = n[26] ? e[7:0] : 8'd0;
    rnd = n[2] && (n[1] || n[0] || n[3]);
    if (x_nan || y_nan || (x_inf && y_inf && (x[31] != y[31]))) begin
      res = CANON_NAN;
    end else if (x_inf) begin
      res = x;
    end else if (y_inf) begin
      res = y;
    end else if (s == 28'd0) begin
      res = {sa & sb, 31'd0};
    end else if (e >= 9'd255) begin
      res = {sa, POS_INF[30:0]};
    end else begin
      res = {sa, ef, n[25:3]} + 32'(rnd);
    end
    return res;
  endfunction

endpackage

// ===== rtl/bqd_ifs.sv =====
// bqd_ifs: valid/ready channel interfaces for input, result and configuration.
// Depends on nothing.
interface bqd_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] value;
  modport source (output valid, kind, value, input ready);
  modport sink (input valid, kind, value, output ready);
endinterface

interface bqd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] dot_bits;
  logic [15:0] vector_index;
  modport source (output valid, dot_bits, vector_index, input ready);
  modport sink (input valid, dot_bits, vector_index, output ready);
endinterface

interface bqd_cfg_if;
  logic        valid;
  logic        ready;
  logic [10:0] vector_length;
  modport source (output valid, vector_length, input ready);
  modport sink (input valid, vector_length, output ready);
endinterface

// ===== rtl/bqd_front.sv =====
// bqd_front: accepts beats, holds the query store and positions, issues base ops.
// Depends on bqd_pkg.
module bqd_front #(
  parameter int unsigned MAX_DIM = 1024
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_kind,
  input  logic [15:0]              in_value,
  output logic                     in_ready,
  input  logic [bqd_pkg::CFG_W-1:0] vec_len,
  input  logic                     q_afull,
  output logic                     push,
  output bqd_pkg::op_t             push_op
);

  localparam int unsigned AW = $clog2(MAX_DIM);
  localparam int unsigned LW = $clog2(MAX_DIM + 1);
  localparam int unsigned CW = (LW > bqd_pkg::CFG_W) ? LW : bqd_pkg::CFG_W;

  logic [15:0]   qmem [MAX_DIM];
  logic [15:0]   q_rd_r;
  logic [AW-1:0] ld_pos_r, ld_pos_nxt;
  logic [AW-1:0] el_pos_r, el_pos_nxt;
  logic [15:0]   vcnt_r, vcnt_nxt;
  logic          s1_valid_r;
  logic [15:0]   s1_base_r;
  logic          s1_first_r, s1_last_r;
  logic [15:0]   s1_vidx_r;
  logic [CW-1:0] len;
  logic          acc_beat, ld_beat, base_beat, el_last, ld_wrap;

  assign in_ready  = !q_afull;
  assign acc_beat  = in_valid && in_ready;
  assign ld_beat   = acc_beat && (in_kind == bqd_pkg::KIND_QUERY);
  assign base_beat = acc_beat && (in_kind == bqd_pkg::KIND_BASE);

  // length clamped to 1..MAX_DIM
  always_comb begin
    if (vec_len == '0) begin
      len = CW'(1);
    end else if (CW'(vec_len) > CW'(MAX_DIM)) begin
      len = CW'(MAX_DIM);
    end else begin
      len = CW'(vec_len);
    end
  end

  assign el_last = (CW'(el_pos_r) + CW'(1)) >= len;
  assign ld_wrap = (CW'(ld_pos_r) + CW'(1)) >= len;

  always_comb begin
    ld_pos_nxt = ld_pos_r;
    el_pos_nxt = el_pos_r;
    vcnt_nxt   = vcnt_r;
    if (ld_beat) begin
      ld_pos_nxt = ld_wrap ? '0 : ld_pos_r + AW'(1);
      el_pos_nxt = '0;
      vcnt_nxt   = '0;
    end else if (base_beat) begin
      el_pos_nxt = el_last ? '0 : el_pos_r + AW'(1);
      vcnt_nxt   = el_last ? vcnt_r + 16'd1 : vcnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld_pos_r   <= '0;
      el_pos_r   <= '0;
      vcnt_r     <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      ld_pos_r   <= ld_pos_nxt;
      el_pos_r   <= el_pos_nxt;
      vcnt_r     <= vcnt_nxt;
      s1_valid_r <= base_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_beat) begin
      qmem[ld_pos_r] <= in_value;
    end
    if (base_beat) begin
      q_rd_r     <= qmem[el_pos_r];
      s1_base_r  <= in_value;
      s1_first_r <= (el_pos_r == '0);
      s1_last_r  <= el_last;
      s1_vidx_r  <= vcnt_r;
    end
  end

  // queue room is reserved at accept time, so the push never waits
  assign push    = s1_valid_r;
  assign push_op = '{base: s1_base_r, query: q_rd_r, first: s1_first_r,
                     last: s1_last_r, vidx: s1_vidx_r};

  a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ld_beat |=> (el_pos_r == '0) && (vcnt_r == '0))
    else $error("query load did not clear element position");

  a_push_src: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> $past(base_beat))
    else $error("push without base beat");

endmodule

// ===== rtl/bqd_queue.sv =====
// bqd_queue: short FIFO of base ops between front and back.
// Depends on bqd_pkg.
module bqd_queue (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  bqd_pkg::op_t push_op,
  input  logic         pop,
  output logic         q_valid,
  output bqd_pkg::op_t q_op,
  output logic         q_afull
);

  bqd_pkg::op_t            mem_r [bqd_pkg::Q_DEPTH];
  logic [bqd_pkg::Q_PW-1:0] wp_r, rp_r;
  logic [bqd_pkg::Q_CW-1:0] cnt_r;

  assign q_valid = (cnt_r != '0);
  assign q_op    = mem_r[rp_r];
  // one slot kept spare for the beat sitting in the front's read stage
  assign q_afull = (cnt_r >= bqd_pkg::Q_CW'(bqd_pkg::Q_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + bqd_pkg::Q_PW'(1);
      if (pop)  rp_r <= rp_r + bqd_pkg::Q_PW'(1);
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + bqd_pkg::Q_CW'(1);
        2'b01:   cnt_r <= cnt_r - bqd_pkg::Q_CW'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_op;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r < bqd_pkg::Q_CW'(bqd_pkg::Q_DEPTH)))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (cnt_r != '0))
    else $error("queue underflow");

endmodule

// ===== rtl/bqd_back.sv =====
// bqd_back: bf16 multiply stage, fp32 accumulate stage and result register.
// Depends on bqd_pkg.
module bqd_back (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_valid,
  input  bqd_pkg::op_t q_op,
  output logic         pop,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [31:0]  out_dot,
  output logic [15:0]  out_idx
);

  bqd_pkg::prod_t p_r;
  logic           p_valid_r;
  logic [31:0]    acc_r, acc_nxt;
  logic           out_valid_r;
  logic [31:0]    out_dot_r;
  logic [15:0]    out_idx_r;
  logic           adv;

  // whole back end moves together; it halts only when a result is stuck
  assign adv = !out_valid_r || out_ready;
  assign pop = q_valid && adv;

  always_ff @(posedge clk) begin
    if (adv && q_valid) begin
      p_r <= '{prod: bqd_pkg::bf16_mul(q_op.base, q_op.query), first: q_op.first,
               last: q_op.last, vidx: q_op.vidx};
    end
  end

  // first element of a vector starts from +0
  assign acc_nxt = bqd_pkg::fp32_canon(
    bqd_pkg::fp32_add(p_r.first ? bqd_pkg::POS_ZERO : acc_r, p_r.prod));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= bqd_pkg::POS_ZERO;
    end else if (adv) begin
      p_valid_r   <= q_valid;
      out_valid_r <= p_valid_r && p_r.last;
      if (p_valid_r) acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && p_valid_r && p_r.last) begin
      out_dot_r <= acc_nxt;
      out_idx_r <= p_r.vidx;
    end
  end

  assign out_valid = out_valid_r;
  assign out_dot   = out_dot_r;
  assign out_idx   = out_idx_r;

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(p_valid_r && p_r.last))
    else $error("result without last element");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (p_valid_r && !adv) |=> p_valid_r)
    else $error("product stage lost during stall");

endmodule

// ===== rtl/bf16_query_batch_dot.sv =====
// bf16_query_batch_dot: top level; front, queue and back with the length register.
// Path: front read stage, queue, product register, then result register.
// Throughput: one element per cycle while the result side does not stall; set by the
// combinational fp32 add in the accumulate loop of the back end.
// Reset: control state cleared, vector_length set to 1024; query store not cleared.
// Depends on bqd_pkg, bqd_ifs, bqd_front, bqd_queue, bqd_back.
module bf16_query_batch_dot #(
  parameter int unsigned MAX_DIM = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  bqd_in_if.sink    in_ch,
  bqd_out_if.source out_ch,
  bqd_cfg_if.sink   cfg_ch
);

  logic [bqd_pkg::CFG_W-1:0] vlen_r;
  logic                      push, pop, q_valid, q_afull;
  bqd_pkg::op_t              push_op, q_op;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vlen_r <= bqd_pkg::LEN_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      vlen_r <= cfg_ch.vector_length;
    end
  end

  bqd_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_kind  (in_ch.kind),
    .in_value (in_ch.value),
    .in_ready (in_ch.ready),
    .vec_len  (vlen_r),
    .q_afull  (q_afull),
    .push     (push),
    .push_op  (push_op)
  );

  bqd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .q_valid (q_valid),
    .q_op    (q_op),
    .q_afull (q_afull)
  );

  bqd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_op      (q_op),
    .pop       (pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_dot   (out_ch.dot_bits),
    .out_idx   (out_ch.vector_index)
  );

endmodule

// ===== tb/bf16_query_batch_dot_tb.sv =====
// Testbench for bf16_query_batch_dot: streams query and base elements at random rates,
// predicts each dot product in the scoreboard class and checks every result beat.
// Depends on bqd_pkg, bqd_ifs and the RTL of bf16_query_batch_dot.
`timescale 1ns / 100ps

module bf16_query_batch_dot_tb;

  localparam int unsigned DIM = 1024;

  typedef struct {
    logic [31:0] dot;
    logic [15:0] idx;
  } dot_result_t;

  class dot_scoreboard;
    logic [15:0] query_mem [DIM];
    bit          loaded [DIM];
    int unsigned load_pos, elem_pos, vlen;
    logic [31:0] acc;
    logic [15:0] vcount;
    dot_result_t pending [$];
    int unsigned errors, results, queries, bases;

    function new();
      foreach (loaded[i]) loaded[i] = 0;
      load_pos = 0;
      elem_pos = 0;
      acc      = bqd_pkg::POS_ZERO;
      vcount   = 0;
      vlen     = DIM;
      errors   = 0;
      results  = 0;
      queries  = 0;
      bases    = 0;
    endfunction

    function int unsigned eff_len();
      if (vlen == 0) return 1;
      if (vlen > DIM) return DIM;
      return vlen;
    endfunction

    static function real fp32_to_real(logic [31:0] f);
      logic [63:0] b;
      real         r;
      if (f[30:23] == 8'hFF)
        b = {f[31], 11'h7FF, (f[22:0] != 0) ? 52'h8_0000_0000_0000 : 52'h0};
      else if (f[30:23] != 0)
        b = {f[31], 11'(f[30:23]) + 11'd896, f[22:0], 29'd0};
      else
        b = {f[31], 63'd0};
      r = $bitstoreal(b);
      if (f[30:23] == 0 && f[22:0] != 0) begin
        r = real'(f[22:0]) * 2.0 ** (-149);
        if (f[31]) r = -r;
      end
      return r;
    endfunction

    // round a double to fp32, nearest even, subnormals kept
    static function logic [31:0] real_to_fp32(real r);
      logic [63:0]     b;
      int              fe, sh;
      longint unsigned sig, mant, rem, half;
      logic [31:0]     res;
      b = $realtobits(r);
      if (b[62:52] == 11'h7FF)
        return (b[51:0] != 0) ? bqd_pkg::CANON_NAN : {b[63], bqd_pkg::POS_INF[30:0]};
      if (b[62:0] == 0) return {b[63], 31'd0};
      fe = int'(b[62:52]) - 1023 + 127;
      if (fe >= 255) return {b[63], bqd_pkg::POS_INF[30:0]};
      sig = {11'd0, 1'b1, b[51:0]};
      sh  = 29;
      if (fe < 1) sh = 29 + 1 - fe;
      if (sh > 63) sh = 63;
      mant = sig >> sh;
      rem  = sig & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      res  = (fe >= 1) ? {b[63], 8'(fe), 23'(mant)} : {b[63], 31'(mant)};
      if (rem > half || (rem == half && mant[0])) res = res + 1;
      return res;
    endfunction

    function void note_input(logic kind, logic [15:0] value);
      int unsigned len, pos;
      logic [31:0] prod;
      len = eff_len();
      if (kind == bqd_pkg::KIND_QUERY) begin
        pos = load_pos % DIM;
        query_mem[pos] = value;
        loaded[pos]    = 1;
        load_pos = (pos + 1 >= len) ? 0 : pos + 1;
        elem_pos = 0;
        acc      = bqd_pkg::POS_ZERO;
        vcount   = 0;
        queries++;
        return;
      end
      bases++;
      pos  = elem_pos % DIM;
      prod = real_to_fp32(fp32_to_real({value, 16'd0}) *
                          fp32_to_real({query_mem[pos], 16'd0}));
      acc  = real_to_fp32(fp32_to_real(acc) + fp32_to_real(prod));
      if (pos + 1 >= len) begin
        pending.push_back('{dot: acc, idx: vcount});
        vcount++;
        acc      = bqd_pkg::POS_ZERO;
        elem_pos = 0;
      end else begin
        elem_pos = pos + 1;
      end
    endfunction

    function void check_result(logic [31:0] dot, logic [15:0] idx);
      dot_result_t e;
      results++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result dot=%h index=%0d", $time, dot, idx);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (dot !== e.dot) begin
        $display("%0t: dot_bits expected %h actual %h", $time, e.dot, dot);
        errors++;
      end
      if (idx !== e.idx) begin
        $display("%0t: vector_index expected %0d actual %0d", $time, e.idx, idx);
        errors++;
      end
    endfunction

    // a base element may only be sent where its query entry has been written
    function bit base_allowed();
      return loaded[elem_pos % DIM];
    endfunction
  endclass

  logic clk;
  logic rst_n;

  bqd_in_if  in_ch ();
  bqd_out_if out_ch ();
  bqd_cfg_if cfg_ch ();

  bf16_query_batch_dot i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  dot_scoreboard sb = new();
  logic [15:0]   specials [12] = '{16'h0000, 16'h8000, 16'h7F80, 16'hFF80, 16'h7FC0,
                                   16'h0001, 16'h807F, 16'h7F7F, 16'hFF7F, 16'h0080,
                                   16'h3F80, 16'hFFFF};
  bit            long_stall_done = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic logic [15:0] pick_value();
    if ($urandom_range(3) == 0) return specials[$urandom_range(11)];
    return 16'($urandom);
  endfunction

  task automatic send_elem(logic kind, logic [15:0] value);
    int unsigned gap;
    gap = $urandom_range(4);
    if ($urandom_range(7) == 0) gap = 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind  <= kind;
    in_ch.value <= value;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    sb.note_input(kind, value);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_length(logic [10:0] len);
    cfg_ch.valid         <= 1'b1;
    cfg_ch.vector_length <= len;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    cfg_ch.valid <= 1'b0;
    sb.vlen = len;
  endtask

  task automatic run_phase(logic [10:0] len, int unsigned n_items, bit mid_pause);
    int unsigned fill;
    write_length(len);
    fill = sb.eff_len() + 1;
    repeat (fill) send_elem(bqd_pkg::KIND_QUERY, pick_value());
    for (int i = 0; i < n_items; i++) begin
      if (mid_pause && i == n_items / 2) drain();
      if ($urandom_range(19) == 0 || !sb.base_allowed())
        send_elem(bqd_pkg::KIND_QUERY, pick_value());
      else
        send_elem(bqd_pkg::KIND_BASE, pick_value());
    end
    drain();
  endtask

  // result side: random stalls, one long hold-off to back the block up
  initial begin
    int unsigned gap;
    gap = 0;
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result(out_ch.dot_bits, out_ch.vector_index);
        gap = $urandom_range(4);
        if ($urandom_range(3) == 0) gap = 0;
      end
      if (!long_stall_done && sb.results >= 20) begin
        long_stall_done = 1;
        gap = 300;
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        gap--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    logic [10:0] lens [9] = '{11'd4, 11'd60, 11'd1, 11'd0, 11'd3, 11'd7, 11'd16,
                              11'd33, 11'd2};
    int unsigned counts [9] = '{0, 250, 150, 100, 150, 150, 200, 300, 100};
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.kind           <= bqd_pkg::KIND_QUERY;
    in_ch.value          <= 16'd0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.vector_length <= 11'd0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: overflow, subnormal inputs, infinities, NaN, signed zeros
    write_length(lens[0]);
    foreach (specials[i]) if (i < 4) send_elem(bqd_pkg::KIND_QUERY, specials[i + 7]);
    send_elem(bqd_pkg::KIND_BASE, 16'h7F7F);
    send_elem(bqd_pkg::KIND_BASE, 16'h0001);
    send_elem(bqd_pkg::KIND_BASE, 16'h0000);
    send_elem(bqd_pkg::KIND_BASE, 16'h8000);
    send_elem(bqd_pkg::KIND_BASE, 16'h0080);
    send_elem(bqd_pkg::KIND_BASE, 16'h807F);
    send_elem(bqd_pkg::KIND_BASE, 16'h7F80);
    send_elem(bqd_pkg::KIND_QUERY, 16'h7FC0);
    send_elem(bqd_pkg::KIND_BASE, 16'h7FC0);
    send_elem(bqd_pkg::KIND_BASE, 16'hFFFF);
    send_elem(bqd_pkg::KIND_BASE, 16'h3F80);
    send_elem(bqd_pkg::KIND_BASE, 16'hFF80);
    drain();

    for (int p = 1; p < 9; p++) run_phase(lens[p], counts[p], p == 4);

    $display("Covered %0d query beats, %0d base beats, %0d results over %0d lengths.",
             sb.queries, sb.bases, sb.results, 9);
    if (sb.pending.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/bqd_pkg.sv
rtl/bqd_ifs.sv
rtl/bqd_front.sv
rtl/bqd_queue.sv
rtl/bqd_back.sv
rtl/bf16_query_batch_dot.sv
tb/bf16_query_batch_dot_tb.sv
